>>> rtl/core/fifo_with_delete_and_promote_macros.svh
// Assertion macros for the job queue checker.
// Depends on nothing; included by fwdp_checker.sv.
`ifndef FIFO_WITH_DELETE_AND_PROMOTE_MACROS_SVH
`define FIFO_WITH_DELETE_AND_PROMOTE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define FWDP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Signal must hold its value while a condition held in the previous cycle.
`define FWDP_ASSERT_HOLD(lbl, clk, rstn, cond, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> $stable(sig)) \
        else $error(msg);

`endif

>>> rtl/core/fwdp_pkg.sv
// Shared types and codes for the job queue with delete and promote.
// Used by fwdp_cell, the top level and the checker.
package fwdp_pkg;

    localparam int ID_W    = 16;
    localparam int BYTES_W = 16;
    localparam int COUNT_W = 5;

    typedef enum logic [1:0] {
        REQ_ENQ     = 2'd0,
        REQ_DEQ     = 2'd1,
        REQ_DEL     = 2'd2,
        REQ_PROMOTE = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_AT_HEAD   = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [BYTES_W-1:0] bytes;
    } entry_t;

    // Broadcast to every cell for the word being accepted.
    typedef struct packed {
        logic            enq;      // append at first empty cell
        logic            remove;   // close the gap at the hit cell
        logic            promote;  // shift right up to the hit cell
        logic            by_head;  // every valid cell matches (dequeue)
        logic [ID_W-1:0] key;
        entry_t          new_entry;
    } cell_cmd_t;

endpackage

>>> rtl/core/fwdp_cell.sv
// One queue slot: holds an entry, matches its id, shifts with its neighbors.
// Depends on fwdp_pkg.
module fwdp_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  fwdp_pkg::cell_cmd_t cmd,
    input  fwdp_pkg::entry_t  left_entry,
    input  logic              left_valid,
    input  fwdp_pkg::entry_t  right_entry,
    input  logic              right_valid,
    input  logic              before_in,
    output logic              before_out,
    output logic              hit,
    output logic              valid,
    output fwdp_pkg::entry_t  entry
);
    import fwdp_pkg::*;

    logic   valid_reg, valid_next;
    entry_t entry_reg, entry_next;
    logic   take_right, take_left, take_new;

    assign hit        = valid_reg && (cmd.by_head || entry_reg.id == cmd.key) && !before_in;
    assign before_out = before_in || hit;

    assign take_right = cmd.remove && (before_in || hit);
    assign take_left  = cmd.promote && !before_in;
    assign take_new   = cmd.enq && left_valid && !valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (take_right)
        begin
            valid_next = right_valid;
            entry_next = right_entry;
        end
        else if (take_left)
        begin
            entry_next = left_entry;
        end
        else if (take_new)
        begin
            valid_next = 1'b1;
            entry_next = cmd.new_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign valid = valid_reg;
    assign entry = entry_reg;

endmodule

>>> rtl/core/fifo_with_delete_and_promote.sv
// Ordered job queue with enqueue, dequeue, delete by id and promote to head.
// Depends on fwdp_pkg and fwdp_cell.
//
// The queue is a row of QUEUE_DEPTH cells, head in cell 0. For every request
// word, all cells compare their id against the key
// at once, a priority chain through the row picks the match nearest the
// head, and the cells shift left (dequeue, delete) or right (promote) or
// the first empty cell loads (enqueue) at the same clock edge. The result
// word appears in the output register on the next cycle, so the block takes
// one request per cycle while results are drained; the cell chain's match
// ripple sets the clock period. Results carry the entry count after the
// request, truncated to five bits.
module fifo_with_delete_and_promote #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // doc_id[15:0], doc_bytes[31:16]
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // out_id[15:0], out_bytes[31:16],
                                        // queue_count[36:32], zero[39:37]
    output logic [2:0]  m_axis_tuser    // status[2:0]
);
    import fwdp_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cell_cmd_t            cmd;
    entry_t               cell_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_valid;
    logic [QUEUE_DEPTH-1:0] cell_hit;
    logic [QUEUE_DEPTH:0]   ahead;
    entry_t               sel_entry;
    logic                 accept, found, full, empty;
    req_t                 kind;

    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 out_valid_reg;
    status_t              out_status_reg, out_status_next;
    entry_t               out_entry_reg, out_entry_next;
    logic [COUNT_W-1:0]   out_count_reg;

    assign kind          = req_t'(s_axis_tuser);
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign empty         = !cell_valid[0];
    assign full          = cell_valid[QUEUE_DEPTH-1];
    assign found         = ahead[QUEUE_DEPTH];
    assign ahead[0]      = 1'b0;

    always_comb
    begin
        cmd.enq             = accept && kind == REQ_ENQ;
        cmd.remove          = accept && found && (kind == REQ_DEQ || kind == REQ_DEL);
        cmd.promote         = accept && found && kind == REQ_PROMOTE && !cell_hit[0];
        cmd.by_head         = kind == REQ_DEQ;
        cmd.key             = s_axis_tdata[15:0];
        cmd.new_entry.id    = s_axis_tdata[15:0];
        cmd.new_entry.bytes = s_axis_tdata[31:16];
    end

    always_comb
    begin
        sel_entry = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
            sel_entry = sel_entry | (cell_hit[i] ? cell_entry[i] : '0);
    end

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        entry_t left_e, right_e;
        logic   left_v, right_v;

        if (i == 0)
        begin : g_head
            assign left_e = sel_entry;
            assign left_v = 1'b1;
        end
        else
        begin : g_mid
            assign left_e = cell_entry[i-1];
            assign left_v = cell_valid[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right_e = '0;
            assign right_v = 1'b0;
        end
        else
        begin : g_body
            assign right_e = cell_entry[i+1];
            assign right_v = cell_valid[i+1];
        end

        fwdp_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .left_entry  (left_e),
            .left_valid  (left_v),
            .right_entry (right_e),
            .right_valid (right_v),
            .before_in   (ahead[i]),
            .before_out  (ahead[i+1]),
            .hit         (cell_hit[i]),
            .valid       (cell_valid[i]),
            .entry       (cell_entry[i])
        );
    end

    always_comb
    begin
        count_next      = count_reg;
        out_status_next = ST_OK;
        out_entry_next  = '0;
        if (kind == REQ_ENQ)
        begin
            if (full)
                out_status_next = ST_FULL;
            else
                count_next = count_reg + CNT_W'(1);
        end
        else if (empty)
        begin
            out_status_next = ST_EMPTY;
        end
        else if (!found)
        begin
            out_status_next = ST_NOT_FOUND;
        end
        else
        begin
            out_entry_next = sel_entry;
            if (kind == REQ_PROMOTE)
            begin
                if (cell_hit[0])
                    out_status_next = ST_AT_HEAD;
            end
            else
            begin
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                count_reg <= count_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_status_reg <= out_status_next;
            out_entry_reg  <= out_entry_next;
            out_count_reg  <= COUNT_W'(count_next);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {3'b000, out_count_reg, out_entry_reg.bytes, out_entry_reg.id};

endmodule

>>> rtl/core/fwdp_checker.sv
// Port-level checks for the job queue, bound to the top level.
// Depends on fwdp_pkg and fifo_with_delete_and_promote_macros.svh.
`include "fifo_with_delete_and_promote_macros.svh"

module fwdp_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);
    import fwdp_pkg::*;

    localparam logic [COUNT_W-1:0] DEPTH_LOW = COUNT_W'(QUEUE_DEPTH);

    logic               out_stall, show_empty, show_full, show_miss;
    logic [COUNT_W-1:0] res_count;

    assign out_stall  = m_axis_tvalid && !m_axis_tready;
    assign show_empty = m_axis_tvalid && m_axis_tuser == ST_EMPTY;
    assign show_full  = m_axis_tvalid && m_axis_tuser == ST_FULL;
    assign show_miss  = m_axis_tvalid && (m_axis_tuser == ST_EMPTY || m_axis_tuser == ST_NOT_FOUND);
    assign res_count  = m_axis_tdata[36:32];

    `FWDP_ASSERT_HOLD(a_out_hold, clk, rst_n, out_stall, m_axis_tdata, "result moved in stall")
    `FWDP_ASSERT(a_empty_count, clk, rst_n, show_empty |-> res_count == '0, "empty with count")
    `FWDP_ASSERT(a_full_count, clk, rst_n, show_full |-> res_count == DEPTH_LOW, "full below depth")
    `FWDP_ASSERT(a_miss_zero, clk, rst_n, show_miss |-> m_axis_tdata[31:0] == '0, "miss with data")

endmodule

bind fifo_with_delete_and_promote fwdp_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_fwdp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
